/* rtl/shfr_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sync header frame receiver package
// Shared constants, codes and the command/status structs that join the
// controller and the datapath.
// ----------------------------------------------------------------------------
package shfr_pkg;

  // Field widths fixed by the stream format.
  localparam int DATA_W = 8;
  localparam int POS_W  = 6;

  // Default payload length in bytes; a frame is header plus payload.
  localparam int PAYLOAD_LEN_DEF = 16;

  // Header bytes: '$' then 'A'.
  localparam logic [DATA_W-1:0] HDR_FIRST  = 8'h24;
  localparam logic [DATA_W-1:0] HDR_SECOND = 8'h41;

  // Input kinds carried on in_tuser.
  localparam logic CMD_BYTE    = 1'b0;
  localparam logic CMD_RELEASE = 1'b1;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic             wr_en;       // store rx_byte at wr_addr
    logic [POS_W-1:0] wr_addr;
    logic             xor_init;    // start checksum with rx_byte
    logic             xor_acc;     // fold rx_byte into checksum
    logic             chk_capture; // latch checksum verdict for final byte
    logic             rd_en;       // read frame store at rd_addr
    logic [POS_W-1:0] rd_addr;
    logic             out_load;    // move read data into the output register
    logic [POS_W-1:0] out_pos;
    logic             out_last;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic is_first;   // rx_byte matches the first header byte
    logic is_second;  // rx_byte matches the second header byte
    logic out_free;   // output register can take a new transaction
  } dp_status_t;

endpackage

/* rtl/shfr_datapath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sync header frame receiver datapath
// Frame store memory, running XOR checksum, header compare and the
// output register of the result stream.
// ----------------------------------------------------------------------------
module shfr_datapath #(
  parameter int FRAME_LEN = shfr_pkg::PAYLOAD_LEN_DEF + 2
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic [shfr_pkg::DATA_W-1:0] rx_byte,
  input  shfr_pkg::dp_cmd_t           cmd,
  output shfr_pkg::dp_status_t        status,
  input  logic                        out_ready,
  output logic                        out_valid,
  output logic [shfr_pkg::DATA_W-1:0] out_byte,
  output logic [shfr_pkg::POS_W-1:0]  out_pos,
  output logic                        out_last,
  output logic                        out_ok
);

  localparam int ADDR_W = $clog2(FRAME_LEN);

  logic [shfr_pkg::DATA_W-1:0] mem [FRAME_LEN];
  logic [shfr_pkg::DATA_W-1:0] rd_data_r;
  logic [shfr_pkg::DATA_W-1:0] xor_r;
  logic                        chk_ok_r;
  logic                        out_valid_r;
  logic [shfr_pkg::DATA_W-1:0] out_byte_r;
  logic [shfr_pkg::POS_W-1:0]  out_pos_r;
  logic                        out_last_r;
  logic                        out_ok_r;

  // Frame store: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem[cmd.wr_addr[ADDR_W-1:0]] <= rx_byte;
    end
    if (cmd.rd_en) begin
      rd_data_r <= mem[cmd.rd_addr[ADDR_W-1:0]];
    end
  end

  // Running XOR of the stored bytes and the verdict on the final byte.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      xor_r    <= '0;
      chk_ok_r <= 1'b0;
    end else begin
      if (cmd.xor_init) begin
        xor_r <= rx_byte;
      end else if (cmd.xor_acc) begin
        xor_r <= xor_r ^ rx_byte;
      end
      if (cmd.chk_capture) begin
        chk_ok_r <= (xor_r == rx_byte);
      end
    end
  end

  // Output register; it is free when empty or being drained this cycle.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_byte_r <= rd_data_r;
      out_pos_r  <= cmd.out_pos;
      out_last_r <= cmd.out_last;
      out_ok_r   <= cmd.out_last & chk_ok_r;
    end
  end

  // Status back to the controller.
  assign status.is_first  = (rx_byte == shfr_pkg::HDR_FIRST);
  assign status.is_second = (rx_byte == shfr_pkg::HDR_SECOND);
  assign status.out_free  = !out_valid_r || out_ready;

  assign out_valid = out_valid_r;
  assign out_byte  = out_byte_r;
  assign out_pos   = out_pos_r;
  assign out_last  = out_last_r;
  assign out_ok    = out_ok_r;

endmodule

/* rtl/shfr_controller.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sync header frame receiver controller
// Header hunt, fill position and hold flag while receiving; a read
// sequencer that plays the stored frame out once it is complete.
// ----------------------------------------------------------------------------
module shfr_controller #(
  parameter int FRAME_LEN = shfr_pkg::PAYLOAD_LEN_DEF + 2
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic                 in_command,
  output logic                 in_ready,
  input  shfr_pkg::dp_status_t status,
  output shfr_pkg::dp_cmd_t    cmd
);

  localparam int ADDR_W = $clog2(FRAME_LEN);
  localparam logic [ADDR_W-1:0] LAST_POS = ADDR_W'(FRAME_LEN - 1);
  localparam logic [ADDR_W-1:0] POS_FIRST  = ADDR_W'(0);
  localparam logic [ADDR_W-1:0] POS_SECOND = ADDR_W'(1);

  // State codes.
  localparam logic [1:0] ST_RECV    = 2'd0;
  localparam logic [1:0] ST_EMIT_RD = 2'd1;
  localparam logic [1:0] ST_EMIT    = 2'd2;

  logic [1:0]        state_r, state_nxt;
  logic [ADDR_W-1:0] fill_r, fill_nxt;
  logic [ADDR_W-1:0] idx_r, idx_nxt;
  logic              held_r, held_nxt;
  logic              accept;

  assign in_ready = (state_r == ST_RECV);
  assign accept   = in_valid && in_ready;

  // Next state and datapath commands.
  always_comb begin
    state_nxt = state_r;
    fill_nxt  = fill_r;
    idx_nxt   = idx_r;
    held_nxt  = held_r;
    cmd       = '0;
    case (state_r)
      ST_RECV: begin
        if (accept) begin
          if (in_command == shfr_pkg::CMD_RELEASE) begin
            held_nxt = 1'b0;
          end else if (!held_r) begin
            if (fill_r == POS_FIRST) begin
              if (status.is_first) begin
                cmd.wr_en    = 1'b1;
                cmd.xor_init = 1'b1;
                fill_nxt     = POS_SECOND;
              end
            end else if (fill_r == POS_SECOND) begin
              if (status.is_second) begin
                cmd.wr_en   = 1'b1;
                cmd.xor_acc = 1'b1;
                fill_nxt    = fill_r + 1'b1;
              end else begin
                fill_nxt = POS_FIRST;
              end
            end else begin
              cmd.wr_en = 1'b1;
              if (fill_r == LAST_POS) begin
                cmd.chk_capture = 1'b1;
                held_nxt        = 1'b1;
                fill_nxt        = POS_FIRST;
                idx_nxt         = '0;
                state_nxt       = ST_EMIT_RD;
              end else begin
                cmd.xor_acc = 1'b1;
                fill_nxt    = fill_r + 1'b1;
              end
            end
            cmd.wr_addr = shfr_pkg::POS_W'(fill_r);
          end
        end
      end
      ST_EMIT_RD: begin
        // Prime the read register with the first stored byte.
        cmd.rd_en   = 1'b1;
        cmd.rd_addr = shfr_pkg::POS_W'(idx_r);
        state_nxt   = ST_EMIT;
      end
      ST_EMIT: begin
        // Load one byte per free output slot and read the next one.
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_pos  = shfr_pkg::POS_W'(idx_r);
          cmd.out_last = (idx_r == LAST_POS);
          if (idx_r == LAST_POS) begin
            state_nxt = ST_RECV;
          end else begin
            cmd.rd_en   = 1'b1;
            cmd.rd_addr = shfr_pkg::POS_W'(idx_r + 1'b1);
            idx_nxt     = idx_r + 1'b1;
          end
        end
      end
      default: begin
        state_nxt = ST_RECV;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_RECV;
      fill_r  <= '0;
      idx_r   <= '0;
      held_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      fill_r  <= fill_nxt;
      idx_r   <= idx_nxt;
      held_r  <= held_nxt;
    end
  end

endmodule

/* rtl/sync_header_frame_receiver.sv */
`timescale 1ns / 1ps
// A final frame byte starts playback: the controller steps through ST_EMIT_RD,
// which primes the read register, then ST_EMIT, which fills the output register.
// Throughput: one item per cycle while receiving; during playback the input
// is stalled until the last frame byte is loaded into the output register.
// Reset: synchronous active low; hunting for the header, frame not held.
// ----------------------------------------------------------------------------
// Sync header frame receiver top level
// Hunts for the '$' 'A' header, stores a fixed-length frame and plays it out
// with a last marker and an XOR checksum verdict, then holds until released.
// ----------------------------------------------------------------------------
module sync_header_frame_receiver #(
  parameter int PAYLOAD_LEN = shfr_pkg::PAYLOAD_LEN_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] rx_byte
  input  logic        in_tuser,   // [0] command
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [7:0] frame_byte, [13:8] frame_position, [15:14] zero
  output logic        out_tlast,
  output logic        out_tuser   // [0] checksum_ok
);

  localparam int FRAME_LEN = PAYLOAD_LEN + 2;

  shfr_pkg::dp_cmd_t           cmd;
  shfr_pkg::dp_status_t        status;
  logic [shfr_pkg::DATA_W-1:0] out_byte;
  logic [shfr_pkg::POS_W-1:0]  out_pos;

  shfr_controller #(
    .FRAME_LEN (FRAME_LEN)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_command (in_tuser),
    .in_ready   (in_tready),
    .status     (status),
    .cmd        (cmd)
  );

  shfr_datapath #(
    .FRAME_LEN (FRAME_LEN)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .rx_byte   (in_tdata),
    .cmd       (cmd),
    .status    (status),
    .out_ready (out_tready),
    .out_valid (out_tvalid),
    .out_byte  (out_byte),
    .out_pos   (out_pos),
    .out_last  (out_tlast),
    .out_ok    (out_tuser)
  );

  assign out_tdata = {2'b00, out_pos, out_byte};

`ifndef ASSERT_OFF
  // The last transaction of a frame sits at the final frame position.
  a_last_pos: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tlast |-> out_tdata[13:8] == shfr_pkg::POS_W'(FRAME_LEN - 1))
    else $error("last marker away from final frame position");

  // A checksum verdict is only given on the last byte.
  a_ok_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tlast)
    else $error("checksum flag on a byte that is not last");

  // Position zero of a played frame always carries the first header byte.
  a_header: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[13:8] == 6'd0 |-> out_tdata[7:0] == shfr_pkg::HDR_FIRST)
    else $error("frame does not start with the header byte");

  // While a non-final byte waits, playback is running and input is stalled.
  a_stall: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tlast |-> !in_tready)
    else $error("input accepted during frame playback");
`endif

endmodule
